FILE: design/mhpq_pkg.sv
// Package for the max-heap priority queue: command and status codes, the
// operation travelling along the cell chain and the item carried with it.
// No dependencies.
package mhpq_pkg;

  localparam int KEY_W   = 31;
  localparam int COUNT_W = 7;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL,
    OP_FIND
  } op_t;

  // Travels from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] carry;
    logic             hit;
    logic             shift;
    logic             placed;
  } token_t;

endpackage

FILE: design/mhpq_if.sv
// Handshake interfaces for the request and response channels of the queue.
// Depends on mhpq_pkg for the field widths.
interface mhpq_req_if;
  logic                            valid;
  logic                            ready;
  logic [mhpq_pkg::CMD_W-1:0]      cmd;
  logic [mhpq_pkg::KEY_W-1:0]      value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mhpq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [mhpq_pkg::STAT_W-1:0]     status;
  logic                            found;
  logic [mhpq_pkg::KEY_W-1:0]      max_value;
  logic [mhpq_pkg::COUNT_W-1:0]    count;

  modport source (output valid, output status, output found, output max_value,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input max_value,
                  input count, output ready);
endinterface

FILE: design/mhpq_cell.sv
// One cell of the sorted key chain: holds one key (largest keys nearest the
// head) and processes the operation passing through it.
// Depends on mhpq_pkg.
module mhpq_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [CW-1:0]              cnt,
  input  mhpq_pkg::token_t           tok_in,
  input  logic [mhpq_pkg::KEY_W-1:0] next_key,
  output mhpq_pkg::token_t           tok_out,
  output logic [mhpq_pkg::KEY_W-1:0] key
);

  mhpq_pkg::token_t           tok_next;
  logic                       key_we;
  logic [mhpq_pkg::KEY_W-1:0] key_next;
  logic                       occ;

  assign occ = cnt > CW'(INDEX);

  always_comb begin
    tok_next = tok_in;
    key_we   = 1'b0;
    key_next = tok_in.key;
    if (tok_in.vld) begin
      unique case (tok_in.op)
        mhpq_pkg::OP_FIND: begin
          if (occ && key == tok_in.key) begin
            tok_next.hit = 1'b1;
          end
        end
        mhpq_pkg::OP_INS: begin
          if (tok_in.hit || tok_in.placed) begin
            tok_next = tok_in;
          end else if (tok_in.shift) begin
            // Keys below the insertion point move one cell towards the tail.
            key_we   = 1'b1;
            key_next = tok_in.carry;
            if (occ) begin
              tok_next.carry = key;
            end else begin
              tok_next.shift  = 1'b0;
              tok_next.placed = 1'b1;
            end
          end else if (occ) begin
            if (key == tok_in.key) begin
              tok_next.hit = 1'b1;
            end else if (key < tok_in.key) begin
              key_we         = 1'b1;
              key_next       = tok_in.key;
              tok_next.carry = key;
              tok_next.shift = 1'b1;
            end
          end else begin
            key_we          = 1'b1;
            key_next        = tok_in.key;
            tok_next.placed = 1'b1;
          end
        end
        mhpq_pkg::OP_DEL: begin
          // Every key moves one cell towards the head; the neighbour has
          // not been touched yet because the operation runs head to tail.
          key_we   = 1'b1;
          key_next = next_key;
        end
        mhpq_pkg::OP_NONE: begin
          tok_next = tok_in;
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key <= key_next;
    end
  end

endmodule

FILE: design/max_heap_priority_queue.sv
// Priority queue of distinct keys kept as a chain of DEPTH cells sorted largest first.
// Each operation walks the whole cell chain one cell per cycle; a new request is taken
// only once the previous one has left the chain and its response reached the output.
// A new request is accepted while the previous response still waits to be taken.
// Reset: count 0, capacity 64; stored keys are not cleared.
// Depends on mhpq_pkg, mhpq_if and mhpq_cell.
module max_heap_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  mhpq_req_if.sink                     req,
  mhpq_rsp_if.source                   rsp,
  input  logic                         cfg_we,
  input  logic [mhpq_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > mhpq_pkg::COUNT_W) ? CW : mhpq_pkg::COUNT_W;

  mhpq_pkg::token_t           toks [DEPTH];
  logic [mhpq_pkg::KEY_W-1:0] keys [DEPTH];

  logic [mhpq_pkg::COUNT_W-1:0] capacity;
  logic [CW-1:0]                cnt;
  logic                         busy;
  mhpq_pkg::token_t             launch;
  logic [mhpq_pkg::STAT_W-1:0]  st_q;
  logic [mhpq_pkg::KEY_W-1:0]   maxv_q;

  logic                         pend_v;
  logic [mhpq_pkg::STAT_W-1:0]  pend_status;
  logic                         pend_found;
  logic [mhpq_pkg::KEY_W-1:0]   pend_maxv;
  logic [mhpq_pkg::COUNT_W-1:0] pend_count;

  logic                         out_v;
  logic [mhpq_pkg::STAT_W-1:0]  out_status;
  logic                         out_found;
  logic [mhpq_pkg::KEY_W-1:0]   out_maxv;
  logic [mhpq_pkg::COUNT_W-1:0] out_count;

  logic                         acc;
  logic [LW-1:0]                cap_w;
  logic [LW-1:0]                dep_w;
  logic [LW-1:0]                lim;
  logic                         full;
  mhpq_pkg::op_t                op_sel;
  logic [mhpq_pkg::STAT_W-1:0]  st_sel;
  logic [mhpq_pkg::KEY_W-1:0]   maxv_sel;

  mhpq_pkg::token_t             fin;
  logic [CW-1:0]                cnt_new;
  logic [LW-1:0]                cnt_ext;
  logic [mhpq_pkg::STAT_W-1:0]  fin_status;
  logic                         fin_found;
  logic                         move;

  assign acc       = req.valid && req.ready;
  assign req.ready = !busy;

  assign cap_w = LW'(capacity);
  assign dep_w = LW'(DEPTH);
  assign lim   = (cap_w > dep_w) ? dep_w : cap_w;
  assign full  = LW'(cnt) >= lim;

  always_comb begin
    op_sel   = mhpq_pkg::OP_NONE;
    st_sel   = mhpq_pkg::ST_OK;
    maxv_sel = '0;
    unique case (req.cmd)
      mhpq_pkg::CMD_INSERT: begin
        if (full) begin
          st_sel = mhpq_pkg::ST_FULL;
        end else begin
          op_sel = mhpq_pkg::OP_INS;
        end
      end
      mhpq_pkg::CMD_DELETE: begin
        if (cnt == '0) begin
          st_sel = mhpq_pkg::ST_EMPTY;
        end else begin
          op_sel   = mhpq_pkg::OP_DEL;
          maxv_sel = keys[0];
        end
      end
      mhpq_pkg::CMD_FIND: begin
        op_sel = mhpq_pkg::OP_FIND;
      end
      default: begin
        op_sel = mhpq_pkg::OP_NONE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mhpq_pkg::token_t           t_in;
    logic [mhpq_pkg::KEY_W-1:0] nk;
    if (i == 0) begin : g_head
      assign t_in = launch;
    end else begin : g_body
      assign t_in = toks[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nk = keys[i];
    end else begin : g_next
      assign nk = keys[i+1];
    end
    mhpq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cnt      (cnt),
      .tok_in   (t_in),
      .next_key (nk),
      .tok_out  (toks[i]),
      .key      (keys[i])
    );
  end

  assign fin = toks[DEPTH-1];

  always_comb begin
    cnt_new    = cnt;
    fin_status = st_q;
    fin_found  = 1'b0;
    unique case (fin.op)
      mhpq_pkg::OP_INS: begin
        if (fin.hit) begin
          fin_status = mhpq_pkg::ST_DUP;
        end else begin
          cnt_new = cnt + CW'(1);
        end
      end
      mhpq_pkg::OP_DEL: begin
        cnt_new = cnt - CW'(1);
      end
      mhpq_pkg::OP_FIND: begin
        fin_found = fin.hit;
      end
      default: begin
        cnt_new = cnt;
      end
    endcase
  end

  assign cnt_ext = LW'(cnt_new);
  assign move    = pend_v && (!out_v || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= mhpq_pkg::CAPACITY_RESET;
      cnt        <= '0;
      busy       <= 1'b0;
      launch.vld <= 1'b0;
      pend_v     <= 1'b0;
      out_v      <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end

      launch.vld <= acc;
      if (acc) begin
        busy          <= 1'b1;
        launch.op     <= op_sel;
        launch.key    <= req.value;
        launch.carry  <= '0;
        launch.hit    <= 1'b0;
        launch.shift  <= 1'b0;
        launch.placed <= 1'b0;
        st_q          <= st_sel;
        maxv_q        <= maxv_sel;
      end

      // The count only changes once the operation has left the chain, so
      // every cell sees the count from before this item.
      if (fin.vld) begin
        cnt         <= cnt_new;
        pend_v      <= 1'b1;
        pend_status <= fin_status;
        pend_found  <= fin_found;
        pend_maxv   <= maxv_q;
        pend_count  <= cnt_ext[mhpq_pkg::COUNT_W-1:0];
      end else if (move) begin
        pend_v <= 1'b0;
      end

      if (move) begin
        busy       <= 1'b0;
        out_v      <= 1'b1;
        out_status <= pend_status;
        out_found  <= pend_found;
        out_maxv   <= pend_maxv;
        out_count  <= pend_count;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_v;
  assign rsp.status    = out_status;
  assign rsp.found     = out_found;
  assign rsp.max_value = out_maxv;
  assign rsp.count     = out_count;

endmodule
